// File: rtl/core/lfq_pkg.sv
// Shared types and character constants for the line framer with line queue.
`default_nettype none

package lfq_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] action_t;

    localparam action_t ACT_FEED  = 2'd0;
    localparam action_t ACT_POLL  = 2'd1;
    localparam action_t ACT_CLEAR = 2'd2;

    localparam byte_t CHR_CR    = 8'h0D;
    localparam byte_t CHR_LF    = 8'h0A;
    localparam byte_t CHR_AT    = 8'h40;
    localparam byte_t CHR_D     = 8'h44;
    localparam byte_t CHR_COMMA = 8'h2C;

    // Number of framing bytes ahead of the line text.
    localparam int PREFIX_LEN = 3;

endpackage

`default_nettype wire

// File: rtl/core/lfq_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module lfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/lfq_obuf.sv
// Output register stage for the emitted byte stream.
`default_nettype none

module lfq_obuf (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire lfq_pkg::byte_t in_byte,
    input  wire logic           in_last,
    output logic                m_valid,
    input  wire logic           m_ready,
    output lfq_pkg::byte_t      m_out_byte,
    output logic                m_last_byte
);

    import lfq_pkg::*;

    logic  valid_reg;
    byte_t byte_reg;
    logic  last_reg;

    // Take a new transaction whenever the held one leaves or none is held.
    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_last_byte = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/line_framer_with_line_queue_top.sv
// Top level: line assembly, line queue in RAM and framed line emission.
//
//  port group   | dir | transaction
//  -------------+-----+---------------------------------------------------
//  s_*          | in  | one command: feed byte, poll one line, clear all
//  m_*          | out | one byte of "@D," + line + CR LF, last on the LF
//
//  Feed of an ordinary byte, CR, clear and an empty poll leave s_ready high.
//  An LF that queues a line copies it from the assembly RAM into the queue
//  RAM at one byte per cycle, with s_ready low until the copy is done.
//  A poll emits 5 framing bytes at one per cycle while m_ready allows, and
//  each line byte waits for its RAM read before it is passed on.
//  Back pressure on m_ready stalls emission; s_ready stays low until done.
//  Reset is synchronous on aresetn; the RAMs need no clearing pass.
`default_nettype none

module line_framer_with_line_queue_top #(
    parameter int LINE_BYTES  = 32,
    parameter int QUEUE_LINES = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lfq_pkg::action_t  s_action,
    input  wire lfq_pkg::byte_t    s_data_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lfq_pkg::byte_t         m_out_byte,
    output logic                   m_last_byte
);

    import lfq_pkg::*;

    localparam int FILL_W = $clog2(LINE_BYTES);
    localparam int SLOT_W = (QUEUE_LINES > 1) ? $clog2(QUEUE_LINES) : 1;
    localparam int CNT_W  = $clog2(QUEUE_LINES + 1);
    localparam int QDEPTH = QUEUE_LINES * LINE_BYTES;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int POS_W  = $clog2(LINE_BYTES + PREFIX_LEN + 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SLOT_W-1:0]  wslot_reg, wslot_next;
    logic [SLOT_W-1:0]  rslot_reg, rslot_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [FILL_W-1:0]  cidx_reg, cidx_next;
    logic               cwr_en_reg, cwr_en_next;
    logic [FILL_W-1:0]  cwr_idx_reg, cwr_idx_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               rdv_reg, rdv_next;

    logic [FILL_W-1:0]  len_reg [QUEUE_LINES];
    logic               len_we;

    logic               accept;
    logic               is_cr, is_lf;
    logic               asm_we;
    byte_t              asm_rdata;
    logic [QA_W-1:0]    q_waddr, q_raddr;
    byte_t              q_rdata;

    logic [FILL_W-1:0]  emit_len;
    logic [POS_W-1:0]   len_end;
    logic [POS_W-1:0]   data_off;
    logic               data_pos;
    logic               push_valid, push_ready, push, push_last;
    byte_t              push_byte;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign is_cr   = (s_data_byte == CHR_CR);
    assign is_lf   = (s_data_byte == CHR_LF);

    // Append the byte at the fill position while the line has room.
    assign asm_we = accept && (s_action == ACT_FEED) && !is_cr && !is_lf
                    && (fill_reg < FILL_W'(LINE_BYTES - 1));

    lfq_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_asm_ram (
        .clk   (aclk),
        .we    (asm_we),
        .waddr (fill_reg),
        .wdata (s_data_byte),
        .raddr (cidx_reg),
        .rdata (asm_rdata)
    );

    // Queue slots are laid out back to back, LINE_BYTES apart.
    assign q_waddr = QA_W'(wslot_reg) * QA_W'(LINE_BYTES) + QA_W'(cwr_idx_reg);
    assign data_off = pos_reg - POS_W'(PREFIX_LEN);
    assign q_raddr = QA_W'(rslot_reg) * QA_W'(LINE_BYTES) + QA_W'(data_off[FILL_W-1:0]);

    lfq_ram #(
        .WIDTH (8),
        .DEPTH (QDEPTH)
    ) u_queue_ram (
        .clk   (aclk),
        .we    (cwr_en_reg),
        .waddr (q_waddr),
        .wdata (asm_rdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // Emission byte selection: prefix, line text from RAM, CR, then LF.
    assign emit_len = len_reg[rslot_reg];
    assign len_end  = POS_W'(emit_len) + POS_W'(PREFIX_LEN);
    assign data_pos = (pos_reg >= POS_W'(PREFIX_LEN)) && (pos_reg < len_end);

    always_comb begin
        push_last = 1'b0;
        if (pos_reg == POS_W'(0)) begin
            push_byte = CHR_AT;
        end else if (pos_reg == POS_W'(1)) begin
            push_byte = CHR_D;
        end else if (pos_reg == POS_W'(2)) begin
            push_byte = CHR_COMMA;
        end else if (data_pos) begin
            push_byte = q_rdata;
        end else if (pos_reg == len_end) begin
            push_byte = CHR_CR;
        end else begin
            push_byte = CHR_LF;
            push_last = 1'b1;
        end
    end

    // Line bytes wait for the RAM read after the position moves.
    assign push_valid = (state_reg == ST_EMIT) && (!data_pos || rdv_reg);
    assign push       = push_valid && push_ready;

    lfq_obuf u_obuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (push_valid),
        .in_ready    (push_ready),
        .in_byte     (push_byte),
        .in_last     (push_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        wslot_next   = wslot_reg;
        rslot_next   = rslot_reg;
        count_next   = count_reg;
        cidx_next    = cidx_reg;
        cwr_en_next  = 1'b0;
        cwr_idx_next = cwr_idx_reg;
        pos_next     = pos_reg;
        rdv_next     = 1'b0;
        len_we       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        ACT_FEED: begin
                            if (is_lf) begin
                                if ((fill_reg != '0)
                                    && (count_reg < CNT_W'(QUEUE_LINES))) begin
                                    // Start the copy into the queue.
                                    state_next = ST_COPY;
                                    cidx_next  = '0;
                                end else begin
                                    fill_next = '0;
                                end
                            end else if (!is_cr) begin
                                if (fill_reg < FILL_W'(LINE_BYTES - 1)) begin
                                    fill_next = fill_reg + 1'b1;
                                end else begin
                                    fill_next = '0;
                                end
                            end
                        end
                        ACT_POLL: begin
                            if (count_reg != '0) begin
                                state_next = ST_EMIT;
                                pos_next   = '0;
                            end
                        end
                        ACT_CLEAR: begin
                            fill_next  = '0;
                            wslot_next = '0;
                            rslot_next = '0;
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COPY: begin
                // Read one byte per cycle; write it to the queue in the following cycle.
                if (cidx_reg < fill_reg) begin
                    cwr_en_next  = 1'b1;
                    cwr_idx_next = cidx_reg;
                    cidx_next    = cidx_reg + 1'b1;
                end else begin
                    len_we     = 1'b1;
                    wslot_next = (wslot_reg == SLOT_W'(QUEUE_LINES - 1))
                                 ? '0 : wslot_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                rdv_next = !push;
                if (push) begin
                    if (push_last) begin
                        rslot_next = (rslot_reg == SLOT_W'(QUEUE_LINES - 1))
                                     ? '0 : rslot_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            wslot_reg  <= '0;
            rslot_reg  <= '0;
            count_reg  <= '0;
            cwr_en_reg <= 1'b0;
            rdv_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            wslot_reg  <= wslot_next;
            rslot_reg  <= rslot_next;
            count_reg  <= count_next;
            cwr_en_reg <= cwr_en_next;
            rdv_reg    <= rdv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cidx_reg    <= cidx_next;
        cwr_idx_reg <= cwr_idx_next;
        pos_reg     <= pos_next;
        if (len_we) begin
            len_reg[wslot_reg] <= fill_reg;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_LINES))
        else $error("queued line count above capacity");

    a_empty_slots : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wslot_reg == rslot_reg))
        else $error("empty queue with unequal slot pointers");

    a_emit_nonempty : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (count_reg != '0))
        else $error("emission running on an empty queue");

    a_last_is_lf : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_byte) |-> (m_out_byte == CHR_LF))
        else $error("last flag on a byte other than LF");

    a_copy_nonempty : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (fill_reg != '0))
        else $error("copy of an empty line");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for the line framer with line queue: directed and random commands, byte-level scoreboard.
module tb;
    import lfq_pkg::*;

    localparam int LINE_BYTES     = 32;
    localparam int QUEUE_LINES    = 4;
    localparam action_t ACT_UNUSED = 2'd3;   // undefined action code, must do nothing
    localparam int ITEM_TARGET    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 100;

    typedef struct {
        action_t act;
        byte_t   data;
        bit      drain_first;   // hold this command until every framed byte has arrived
    } command_t;

    typedef struct {
        byte_t out_byte;
        logic  last_byte;
    } framed_byte_t;

    logic    aclk        = 1'b0;
    logic    aresetn     = 1'b0;
    logic    s_valid     = 1'b0;
    logic    s_ready;
    action_t s_action    = ACT_FEED;
    byte_t   s_data_byte = 8'h00;
    logic    m_valid;
    logic    m_ready     = 1'b0;
    byte_t   m_out_byte;
    logic    m_last_byte;

    command_t     command_q[$];
    framed_byte_t framed_due[$];
    int unsigned  bytes_owed    = 0;
    int unsigned  mismatches    = 0;
    int unsigned  idle_cycles   = 0;
    int unsigned  cycle_count   = 0;
    int unsigned  send_gap      = 0;
    int unsigned  recv_stall    = 0;
    int unsigned  counted_items = 0;

    // Shadow copy of the line assembler and the line queue.
    byte_t line_buf [LINE_BYTES];
    int    line_fill  = 0;
    byte_t slot_bytes [QUEUE_LINES][LINE_BYTES];
    int    slot_len   [QUEUE_LINES];
    int    wr_slot    = 0;
    int    rd_slot    = 0;
    int    lines_held = 0;

    line_framer_with_line_queue_top #(
        .LINE_BYTES  (LINE_BYTES),
        .QUEUE_LINES (QUEUE_LINES)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Pause length for either side: mostly none, some short, a few long.
    // Every fourth window of the cycle counter (cycle_count >> 10) runs with no pauses at all.
    function automatic int unsigned pick_pause();
        int unsigned roll;
        if (((cycle_count >> 10) % 4) == 0)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 87)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void expect_byte(byte_t b, logic last);
        framed_byte_t fb;
        fb.out_byte  = b;
        fb.last_byte = last;
        framed_due.push_back(fb);
    endfunction

    // Advance the shadow line framer by one command and queue the bytes it emits.
    function automatic void frame_line_step(action_t act, byte_t b);
        case (act)
            ACT_FEED: begin
                if (b == CHR_LF) begin
                    // close the line; drop it if empty or if the queue is full
                    if (line_fill > 0 && lines_held < QUEUE_LINES) begin
                        for (int i = 0; i < line_fill; i++)
                            slot_bytes[wr_slot][i] = line_buf[i];
                        slot_len[wr_slot] = line_fill;
                        wr_slot = (wr_slot + 1) % QUEUE_LINES;
                        lines_held++;
                    end
                    line_fill = 0;
                end else if (b != CHR_CR) begin
                    // overflow drops the byte and restarts the line empty
                    if (line_fill < LINE_BYTES - 1) begin
                        line_buf[line_fill] = b;
                        line_fill++;
                    end else begin
                        line_fill = 0;
                    end
                end
            end
            ACT_POLL: begin
                if (lines_held > 0) begin
                    expect_byte(CHR_AT, 1'b0);
                    expect_byte(CHR_D, 1'b0);
                    expect_byte(CHR_COMMA, 1'b0);
                    for (int i = 0; i < slot_len[rd_slot]; i++)
                        expect_byte(slot_bytes[rd_slot][i], 1'b0);
                    expect_byte(CHR_CR, 1'b0);
                    expect_byte(CHR_LF, 1'b1);
                    rd_slot = (rd_slot + 1) % QUEUE_LINES;
                    lines_held--;
                end
            end
            ACT_CLEAR: begin
                line_fill  = 0;
                wr_slot    = 0;
                rd_slot    = 0;
                lines_held = 0;
            end
            default: begin
            end
        endcase
    endfunction

    // Append one command to the stimulus queue; ignored ones do not count.
    function automatic void add_command(action_t act, byte_t data, bit drain);
        command_t cmd;
        cmd.act         = act;
        cmd.data        = data;
        cmd.drain_first = drain;
        command_q.push_back(cmd);
        if (!(act == ACT_UNUSED || (act == ACT_FEED && data == CHR_CR)))
            counted_items++;
    endfunction

    // Driver: present the next command once the slot is free and its pause is over.
    // A command marked drain_first waits until no framed byte is outstanding.
    always @(posedge aclk) begin
        command_t cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (command_q.size() != 0 &&
                         !(command_q[0].drain_first && (s_valid || bytes_owed != 0))) begin
                cmd = command_q.pop_front();
                s_valid     <= 1'b1;
                s_action    <= cmd.act;
                s_data_byte <= cmd.data;
                send_gap = pick_pause();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted command, then check each accepted byte
    // against the oldest expectation. Stall m_ready at random.
    always @(posedge aclk) begin
        framed_byte_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (s_valid && s_ready)
                frame_line_step(s_action, s_data_byte);
            if (m_valid && m_ready) begin
                if (framed_due.size() == 0) begin
                    $error("unexpected output byte %h (last %b)", m_out_byte, m_last_byte);
                    mismatches++;
                end else begin
                    want = framed_due.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h", want.out_byte, m_out_byte);
                        mismatches++;
                    end
                    if (m_last_byte !== want.last_byte) begin
                        $error("last_byte: expected %b, actual %b", want.last_byte,
                               m_last_byte);
                        mismatches++;
                    end
                end
            end
            bytes_owed <= framed_due.size();
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_stall = pick_pause();
            end
        end
    end

    // Count cycles and the run of cycles without any transaction.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(negedge aclk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int unsigned roll;
        int unsigned pick;
        int unsigned len;
        bit          drain;
        byte_t       b;

        // Directed: extreme bytes, CR ignored, zero byte kept, empty line,
        // empty poll, clear with a line queued and one in progress, unused action.
        add_command(ACT_FEED, 8'h41, 1'b0);
        add_command(ACT_FEED, 8'h00, 1'b0);
        add_command(ACT_FEED, 8'hFF, 1'b0);
        add_command(ACT_FEED, CHR_CR, 1'b0);
        add_command(ACT_FEED, CHR_LF, 1'b0);
        add_command(ACT_FEED, 8'h55, 1'b0);
        add_command(ACT_FEED, CHR_LF, 1'b0);
        add_command(ACT_POLL, 8'hFF, 1'b0);
        add_command(ACT_FEED, CHR_LF, 1'b0);
        add_command(ACT_FEED, 8'h66, 1'b0);
        add_command(ACT_CLEAR, 8'h00, 1'b0);
        add_command(ACT_POLL, 8'h00, 1'b0);
        add_command(ACT_UNUSED, 8'hAA, 1'b0);
        // Fill the queue past its depth: the fifth line is dropped.
        for (int n = 0; n < QUEUE_LINES + 1; n++) begin
            add_command(ACT_FEED, byte_t'(8'h31 + n), 1'b0);
            add_command(ACT_FEED, CHR_LF, 1'b0);
        end
        for (int n = 0; n < QUEUE_LINES + 1; n++)
            add_command(ACT_POLL, 8'h00, 1'b0);

        // Random: mostly whole lines and polls, some long or overflowing lines,
        // occasional clears, unused actions and raw noise.
        // Hold the first random command until the directed output is drained.
        add_command(ACT_POLL, 8'h00, 1'b1);
        while (counted_items < ITEM_TARGET) begin
            roll  = $urandom_range(0, 99);
            drain = ($urandom_range(0, 59) == 0);
            if (roll < 50) begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    len = 0;
                else if (pick < 80)
                    len = $urandom_range(1, 8);
                else if (pick < 92)
                    len = $urandom_range(LINE_BYTES - 3, LINE_BYTES - 1);
                else
                    len = $urandom_range(LINE_BYTES, LINE_BYTES + 8);
                for (int k = 0; k < len; k++) begin
                    b = byte_t'($urandom_range(0, 255));
                    if (b == CHR_LF)
                        b = ~CHR_LF;
                    add_command(ACT_FEED, b, drain && k == 0);
                    if ($urandom_range(0, 19) == 0)
                        add_command(ACT_FEED, CHR_CR, 1'b0);
                end
                // leave a line open now and then so it runs into the next one
                if ($urandom_range(0, 9) != 0)
                    add_command(ACT_FEED, CHR_LF, drain && len == 0);
            end else if (roll < 92) begin
                add_command(ACT_POLL, byte_t'($urandom_range(0, 255)), drain);
            end else if (roll < 95) begin
                add_command(ACT_CLEAR, byte_t'($urandom_range(0, 255)), drain);
            end else if (roll < 97) begin
                add_command(ACT_UNUSED, byte_t'($urandom_range(0, 255)), drain);
            end else begin
                add_command(action_t'($urandom_range(0, 3)), byte_t'($urandom_range(0, 255)),
                            drain);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for all commands to go out and every framed byte to come back.
        @(negedge aclk);
        while (command_q.size() != 0 || s_valid || bytes_owed != 0 || framed_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (framed_due.size() != 0) begin
            $error("%0d expected output bytes never arrived", framed_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
